>>> design/psp_pkg.sv
`timescale 1ns / 1ps

package psp_pkg;

  localparam int ModeW = 9;
  localparam int AbsCntW = 4;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [AbsCntW-1:0] ABS_LEN  = 4'd9;
  localparam logic [AbsCntW-1:0] ABS_OVER = 4'd10;
  localparam logic [ModeW-1:0]   TOP_BIT  = 9'h100;

  typedef enum logic [1:0] {
    PH_SEEK = 2'd0,
    PH_WHO  = 2'd1,
    PH_PERM = 2'd2
  } phase_t;

  typedef struct packed {
    logic [AbsCntW-1:0] count;
    logic               ok;
    logic [ModeW-1:0]   bits;
  } abs_st_t;

  typedef struct packed {
    phase_t           phase;
    logic [2:0]       who;
    logic             assign_op;
    logic [2:0]       perm;
    logic [ModeW-1:0] work;
    logic             err;
  } clause_st_t;

  typedef struct packed {
    logic             err;
    logic [ModeW-1:0] work;
  } finish_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= "A" && c <= "Z") begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [2:0] who_bits(input logic [7:0] lc);
    logic [2:0] r;
    case (lc)
      "u": r = 3'b100;
      "g": r = 3'b010;
      "o": r = 3'b001;
      "a": r = 3'b111;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] perm_bits(input logic [7:0] lc);
    logic [2:0] r;
    case (lc)
      "r": r = 3'b100;
      "w": r = 3'b010;
      "x": r = 3'b001;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

  // Applies one finished clause to the working mode, or flags an error for '+' with no permission.
  function automatic finish_t finish_clause(input clause_st_t st);
    finish_t          f;
    logic [ModeW-1:0] affected;
    logic [ModeW-1:0] bits;
    affected = {{3{st.who[2]}}, {3{st.who[1]}}, {3{st.who[0]}}};
    bits = affected & {3{st.perm}};
    f.err = 1'b0;
    f.work = st.work;
    if (!st.assign_op && st.perm == 3'b000) begin
      f.err = 1'b1;
    end else if (st.assign_op) begin
      f.work = (st.work & ~affected) | bits;
    end else begin
      f.work = st.work | bits;
    end
    return f;
  endfunction

endpackage

>>> design/psp_abs.sv
`timescale 1ns / 1ps

module psp_abs (
  input  psp_pkg::abs_st_t st,
  input  logic [7:0]       lc,
  output psp_pkg::abs_st_t st_next
);
  import psp_pkg::*;

  logic [7:0] want;

  always_comb begin
    case (st.count)
      4'd0, 4'd3, 4'd6: want = "r";
      4'd1, 4'd4, 4'd7: want = "w";
      default:          want = "x";
    endcase
  end

  always_comb begin
    st_next = st;
    if (!is_blank(lc)) begin
      if (st.count < ABS_LEN) begin
        if (lc == want) begin
          st_next.bits = st.bits | (TOP_BIT >> st.count);
        end else if (lc != CH_DASH) begin
          st_next.ok = 1'b0;
        end
        st_next.count = st.count + 4'd1;
      end else begin
        st_next.count = ABS_OVER;
        st_next.ok = 1'b0;
      end
    end
  end

endmodule

>>> design/psp_clause.sv
`timescale 1ns / 1ps

module psp_clause (
  input  psp_pkg::clause_st_t st,
  input  logic [7:0]          lc,
  output psp_pkg::clause_st_t st_next
);
  import psp_pkg::*;

  function automatic clause_st_t seek_step(input clause_st_t s, input logic [7:0] c);
    clause_st_t r;
    logic [2:0] w;
    r = s;
    w = who_bits(c);
    if (is_blank(c) || c == CH_COMMA) begin
      r = s;
    end else if (w != 3'b000) begin
      r.who = w;
      r.phase = PH_WHO;
    end else begin
      r.err = 1'b1;
    end
    return r;
  endfunction

  logic [2:0] w;
  logic [2:0] p;
  finish_t    fin;
  clause_st_t after_fin;

  always_comb begin
    w = who_bits(lc);
    p = perm_bits(lc);
    fin = finish_clause(st);
    after_fin = st;
    after_fin.phase = PH_SEEK;
    after_fin.err = fin.err;
    after_fin.work = fin.work;
    st_next = st;
    if (!st.err) begin
      case (st.phase)
        PH_WHO: begin
          if (w != 3'b000) begin
            st_next.who = st.who | w;
          end else if (lc == CH_PLUS || lc == CH_EQ) begin
            st_next.assign_op = (lc == CH_EQ);
            st_next.perm = 3'b000;
            st_next.phase = PH_PERM;
          end else begin
            st_next.err = 1'b1;
          end
        end
        PH_PERM: begin
          // A non-perm byte closes the clause and, if the clause is valid, is then read afresh.
          if (p != 3'b000) begin
            st_next.perm = st.perm | p;
          end else if (fin.err) begin
            st_next = after_fin;
          end else begin
            st_next = seek_step(after_fin, lc);
          end
        end
        default: begin
          st_next = seek_step(st, lc);
        end
      endcase
    end
  end

endmodule

>>> design/permission_string_parser_core.sv
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// in       in_valid / in_ready   char_in[7:0], last
// out      out_valid / out_ready new_mode[8:0], invalid
//
// One byte is taken every cycle while in_ready is high; the parse state updates in the same cycle.
// The result of a line is registered and appears the cycle after its last
// byte is taken; a new byte is taken while that result waits only if out_ready is high.
// in_ready drops only while a result is held and out_ready is low.
// Synchronous reset clears the held mode to zero and starts a fresh line.

module permission_string_parser_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               char_in,
  input  logic                     last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [psp_pkg::ModeW-1:0] new_mode,
  output logic                     invalid
);
  import psp_pkg::*;

  logic [ModeW-1:0] held_mode;
  logic [ModeW-1:0] held_mode_next;
  abs_st_t          abs_st;
  abs_st_t          abs_step;
  abs_st_t          abs_after;
  clause_st_t       cl_st;
  clause_st_t       cl_step;
  clause_st_t       cl_after;
  logic             line_ended;
  logic             line_ended_after;
  logic [7:0]       lc;
  logic             take;
  logic             bad;
  finish_t          fin;

  assign lc = to_lower(char_in);
  assign take = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  psp_abs u_abs (
    .st      (abs_st),
    .lc      (lc),
    .st_next (abs_step)
  );

  psp_clause u_clause (
    .st      (cl_st),
    .lc      (lc),
    .st_next (cl_step)
  );

  always_comb begin
    abs_after = abs_st;
    cl_after = cl_st;
    line_ended_after = line_ended;
    if (!line_ended) begin
      if (char_in == CH_NL || char_in == CH_NUL) begin
        line_ended_after = 1'b1;
      end else begin
        abs_after = abs_step;
        cl_after = cl_step;
      end
    end

    fin = finish_clause(cl_after);
    held_mode_next = held_mode;
    bad = 1'b0;
    if (abs_after.ok && abs_after.count == ABS_LEN) begin
      held_mode_next = abs_after.bits;
    end else begin
      // A clause still open at the end of the line is closed here.
      bad = (abs_after.count == '0) || (cl_after.phase == PH_WHO) || cl_after.err ||
            (cl_after.phase == PH_PERM && fin.err);
      if (!bad) begin
        held_mode_next = (cl_after.phase == PH_PERM) ? fin.work : cl_after.work;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_mode <= '0;
      abs_st <= '{count: '0, ok: 1'b1, bits: '0};
      cl_st <= '{phase: PH_SEEK, who: '0, assign_op: 1'b0, perm: '0, work: '0, err: 1'b0};
      line_ended <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take && last) begin
        held_mode <= held_mode_next;
        abs_st <= '{count: '0, ok: 1'b1, bits: '0};
        cl_st <= '{phase: PH_SEEK, who: '0, assign_op: 1'b0, perm: '0,
                   work: held_mode_next, err: 1'b0};
        line_ended <= 1'b0;
        out_valid <= 1'b1;
      end else begin
        if (take) begin
          abs_st <= abs_after;
          cl_st <= cl_after;
          line_ended <= line_ended_after;
        end
        if (out_ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && last) begin
      new_mode <= held_mode_next;
      invalid <= bad;
    end
  end

endmodule
